>>> hw/rtl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types, constants and fixed-point helpers for the Twiss transport.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int unsigned Q_W       = 32;  // Q16.16 word
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * Q_W;
  localparam int unsigned SUM_W     = Q_W + 3;  // room for three terms, one doubled
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned APB_AW    = REG_IDX_W + 2;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned PIPE_DEPTH = 4;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BETA_X0       = 3'd0,
    REG_BETA_Y0       = 3'd1,
    REG_ALPHA_X0      = 3'd2,
    REG_ALPHA_Y0      = 3'd3,
    REG_GAMMA_X0      = 3'd4,
    REG_GAMMA_Y0      = 3'd5,
    REG_DISP_X0       = 3'd6,
    REG_DISP_SLOPE_X0 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [Q_W-1:0] r11;
    logic signed [Q_W-1:0] r12;
    logic signed [Q_W-1:0] r21;
    logic signed [Q_W-1:0] r22;
    logic signed [Q_W-1:0] r33;
    logic signed [Q_W-1:0] r34;
    logic signed [Q_W-1:0] r43;
    logic signed [Q_W-1:0] r44;
    logic signed [Q_W-1:0] disp_term_x;
    logic signed [Q_W-1:0] disp_slope_term_x;
    logic                  last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] beta_x;
    logic signed [Q_W-1:0] beta_y;
    logic signed [Q_W-1:0] alpha_x;
    logic signed [Q_W-1:0] alpha_y;
    logic signed [Q_W-1:0] gamma_x;
    logic signed [Q_W-1:0] gamma_y;
    logic signed [Q_W-1:0] disp_x;
    logic signed [Q_W-1:0] disp_slope_x;
    logic                  last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] beta_x0;
    logic signed [Q_W-1:0] beta_y0;
    logic signed [Q_W-1:0] alpha_x0;
    logic signed [Q_W-1:0] alpha_y0;
    logic signed [Q_W-1:0] gamma_x0;
    logic signed [Q_W-1:0] gamma_y0;
    logic signed [Q_W-1:0] disp_x0;
    logic signed [Q_W-1:0] disp_slope_x0;
  } cfg_t;

  // Full product to Q16.16: add half an LSB, arithmetic shift (floor), saturate.
  function automatic logic signed [Q_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = (p + ROUND_HALF) >>> FRAC_BITS;
    if (q > PROD_W'(Q_MAX)) begin
      return Q_MAX;
    end else if (q < PROD_W'(Q_MIN)) begin
      return Q_MIN;
    end
    return q[Q_W-1:0];
  endfunction

  function automatic logic signed [Q_W-1:0] q_sat(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < SUM_W'(Q_MIN)) begin
      return Q_MIN;
    end
    return v[Q_W-1:0];
  endfunction

endpackage

>>> hw/rtl/tpt_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpt_cfg_regs
// APB register file holding the initial Twiss set.
// ----------------------------------------------------------------------------
module tpt_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpt_pkg::APB_AW-1:0]   paddr,
  input  logic [tpt_pkg::APB_DW-1:0]   pwdata,
  output logic [tpt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output tpt_pkg::cfg_t                cfg_o
);
  import tpt_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_BETA_X0:       cfg_d.beta_x0       = pwdata;
        REG_BETA_Y0:       cfg_d.beta_y0       = pwdata;
        REG_ALPHA_X0:      cfg_d.alpha_x0      = pwdata;
        REG_ALPHA_Y0:      cfg_d.alpha_y0      = pwdata;
        REG_GAMMA_X0:      cfg_d.gamma_x0      = pwdata;
        REG_GAMMA_Y0:      cfg_d.gamma_y0      = pwdata;
        REG_DISP_X0:       cfg_d.disp_x0       = pwdata;
        REG_DISP_SLOPE_X0: cfg_d.disp_slope_x0 = pwdata;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BETA_X0:       prdata = cfg_q.beta_x0;
      REG_BETA_Y0:       prdata = cfg_q.beta_y0;
      REG_ALPHA_X0:      prdata = cfg_q.alpha_x0;
      REG_ALPHA_Y0:      prdata = cfg_q.alpha_y0;
      REG_GAMMA_X0:      prdata = cfg_q.gamma_x0;
      REG_GAMMA_Y0:      prdata = cfg_q.gamma_y0;
      REG_DISP_X0:       prdata = cfg_q.disp_x0;
      REG_DISP_SLOPE_X0: prdata = cfg_q.disp_slope_x0;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta_x0       <= Q_ONE;
      cfg_q.beta_y0       <= Q_ONE;
      cfg_q.alpha_x0      <= '0;
      cfg_q.alpha_y0      <= '0;
      cfg_q.gamma_x0      <= Q_ONE;
      cfg_q.gamma_y0      <= Q_ONE;
      cfg_q.disp_x0       <= '0;
      cfg_q.disp_slope_x0 <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/tpt_plane.sv
// ----------------------------------------------------------------------------
// tpt_plane
// Four-stage beta/alpha/gamma transport for one plane's 2x2 block.
// Stage 1 matrix products, stage 2 round/saturate, stage 3 products with the
// initial Twiss values, stage 4 round and combine.
// ----------------------------------------------------------------------------
module tpt_plane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     c_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     s_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     cp_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     sp_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     beta0_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     alpha0_i,
  input  logic signed [tpt_pkg::Q_W-1:0]     gamma0_i,
  output logic signed [tpt_pkg::Q_W-1:0]     beta_o,
  output logic signed [tpt_pkg::Q_W-1:0]     alpha_o,
  output logic signed [tpt_pkg::Q_W-1:0]     gamma_o
);
  import tpt_pkg::*;

  // stage 1: raw products
  logic signed [PROD_W-1:0] cc_q, cs_q, ss_q, ccp_q, csp_q, scp_q, sps_q;
  logic signed [PROD_W-1:0] cpcp_q, spcp_q, spsp_q;
  // stage 2: Q16.16 coefficients
  logic signed [Q_W-1:0] k_cc_q, k_cs_q, k_ss_q, k_ccp_q, k_mid_q, k_sps_q;
  logic signed [Q_W-1:0] k_cpcp_q, k_spcp_q, k_spsp_q;
  logic signed [Q_W-1:0] k_mid_d;
  // stage 3: products with the initial set
  logic signed [PROD_W-1:0] b0_q, b1_q, b2_q, a0_q, a1_q, a2_q, g0_q, g1_q, g2_q;
  // stage 4: terms and results
  logic signed [Q_W-1:0] tb0, tb1, tb2, ta0, ta1, ta2, tg0, tg1, tg2;
  logic signed [Q_W-1:0] beta_d, alpha_d, gamma_d;
  logic signed [Q_W-1:0] beta_q, alpha_q, gamma_q;

  // S(P(c,s') + P(s,c')) is saturated before it meets alpha
  assign k_mid_d = q_sat(SUM_W'(q_round(csp_q)) + SUM_W'(q_round(scp_q)));

  assign tb0 = q_round(b0_q);
  assign tb1 = q_round(b1_q);
  assign tb2 = q_round(b2_q);
  assign ta0 = q_round(a0_q);
  assign ta1 = q_round(a1_q);
  assign ta2 = q_round(a2_q);
  assign tg0 = q_round(g0_q);
  assign tg1 = q_round(g1_q);
  assign tg2 = q_round(g2_q);

  assign beta_d  = q_sat(SUM_W'(tb0) - (SUM_W'(tb1) <<< 1) + SUM_W'(tb2));
  assign alpha_d = q_sat(SUM_W'(ta1) - SUM_W'(ta0) - SUM_W'(ta2));
  assign gamma_d = q_sat(SUM_W'(tg0) - (SUM_W'(tg1) <<< 1) + SUM_W'(tg2));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q     <= c_i * c_i;
      cs_q     <= c_i * s_i;
      ss_q     <= s_i * s_i;
      ccp_q    <= c_i * cp_i;
      csp_q    <= c_i * sp_i;
      scp_q    <= s_i * cp_i;
      sps_q    <= sp_i * s_i;
      cpcp_q   <= cp_i * cp_i;
      spcp_q   <= sp_i * cp_i;
      spsp_q   <= sp_i * sp_i;

      k_cc_q   <= q_round(cc_q);
      k_cs_q   <= q_round(cs_q);
      k_ss_q   <= q_round(ss_q);
      k_ccp_q  <= q_round(ccp_q);
      k_mid_q  <= k_mid_d;
      k_sps_q  <= q_round(sps_q);
      k_cpcp_q <= q_round(cpcp_q);
      k_spcp_q <= q_round(spcp_q);
      k_spsp_q <= q_round(spsp_q);

      b0_q     <= k_cc_q * beta0_i;
      b1_q     <= k_cs_q * alpha0_i;
      b2_q     <= k_ss_q * gamma0_i;
      a0_q     <= k_ccp_q * beta0_i;
      a1_q     <= k_mid_q * alpha0_i;
      a2_q     <= k_sps_q * gamma0_i;
      g0_q     <= k_cpcp_q * beta0_i;
      g1_q     <= k_spcp_q * alpha0_i;
      g2_q     <= k_spsp_q * gamma0_i;

      beta_q   <= beta_d;
      alpha_q  <= alpha_d;
      gamma_q  <= gamma_d;
    end
  end

  assign beta_o  = beta_q;
  assign alpha_o = alpha_q;
  assign gamma_o = gamma_q;

endmodule

>>> hw/rtl/tpt_disp.sv
// ----------------------------------------------------------------------------
// tpt_disp
// Four-stage horizontal dispersion and slope transport.
// ----------------------------------------------------------------------------
module tpt_disp (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [tpt_pkg::Q_W-1:0] r11_i,
  input  logic signed [tpt_pkg::Q_W-1:0] r12_i,
  input  logic signed [tpt_pkg::Q_W-1:0] r21_i,
  input  logic signed [tpt_pkg::Q_W-1:0] r22_i,
  input  logic signed [tpt_pkg::Q_W-1:0] d14_i,
  input  logic signed [tpt_pkg::Q_W-1:0] d24_i,
  input  logic signed [tpt_pkg::Q_W-1:0] disp0_i,
  input  logic signed [tpt_pkg::Q_W-1:0] slope0_i,
  output logic signed [tpt_pkg::Q_W-1:0] disp_o,
  output logic signed [tpt_pkg::Q_W-1:0] slope_o
);
  import tpt_pkg::*;

  logic signed [PROD_W-1:0] p11_q, p12_q, p21_q, p22_q;
  logic signed [Q_W-1:0]    d14_s1_q, d24_s1_q, d14_s2_q, d24_s2_q;
  logic signed [Q_W-1:0]    m11_q, m12_q, m21_q, m22_q;
  logic signed [Q_W-1:0]    disp_s3_q, slope_s3_q, disp_q, slope_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p11_q      <= r11_i * disp0_i;
      p12_q      <= r12_i * slope0_i;
      p21_q      <= r21_i * disp0_i;
      p22_q      <= r22_i * slope0_i;
      d14_s1_q   <= d14_i;
      d24_s1_q   <= d24_i;

      m11_q      <= q_round(p11_q);
      m12_q      <= q_round(p12_q);
      m21_q      <= q_round(p21_q);
      m22_q      <= q_round(p22_q);
      d14_s2_q   <= d14_s1_q;
      d24_s2_q   <= d24_s1_q;

      disp_s3_q  <= q_sat(SUM_W'(m11_q) + SUM_W'(m12_q) + SUM_W'(d14_s2_q));
      slope_s3_q <= q_sat(SUM_W'(m21_q) + SUM_W'(m22_q) + SUM_W'(d24_s2_q));

      // align with the plane pipelines
      disp_q     <= disp_s3_q;
      slope_q    <= slope_s3_q;
    end
  end

  assign disp_o  = disp_q;
  assign slope_o = slope_q;

endmodule

>>> hw/rtl/twiss_parameter_transport.sv
// ----------------------------------------------------------------------------
// twiss_parameter_transport
// Transports the configured Twiss set through one transfer matrix per item.
//
//   channel  | signals                               | dir
//   ---------+---------------------------------------+-----
//   input    | in_valid_i / in_ready_o / in_data_i   | in
//   output   | out_valid_o / out_ready_i / out_data_o| out
//   config   | APB: psel penable pwrite paddr pwdata | in
//            |      prdata pready                    | out
//
// One transfer per cycle in, one per cycle out unless the output stalls;
// results pass through the two multiply/round pairs of the plane pipelines.
// Reset clears the valid bits and loads beta = gamma = 1.0, all else 0.
// A stall on the output freezes all four stages together; input ready
// follows the output register's state and out_ready_i.
// ----------------------------------------------------------------------------
module twiss_parameter_transport (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tpt_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tpt_pkg::out_item_t           out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpt_pkg::APB_AW-1:0]   paddr,
  input  logic [tpt_pkg::APB_DW-1:0]   pwdata,
  output logic [tpt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import tpt_pkg::*;

  cfg_t                  cfg;
  logic                  pipe_en;
  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic [PIPE_DEPTH-1:0] last_q;

  assign pipe_en     = ~vld_q[PIPE_DEPTH-1] | out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  always_comb begin
    vld_d = vld_q;
    if (pipe_en) begin
      vld_d = {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      last_q <= {last_q[PIPE_DEPTH-2:0], in_data_i.last_in};
    end
  end

  tpt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpt_plane u_plane_x (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .c_i      (in_data_i.r11),
    .s_i      (in_data_i.r12),
    .cp_i     (in_data_i.r21),
    .sp_i     (in_data_i.r22),
    .beta0_i  (cfg.beta_x0),
    .alpha0_i (cfg.alpha_x0),
    .gamma0_i (cfg.gamma_x0),
    .beta_o   (out_data_o.beta_x),
    .alpha_o  (out_data_o.alpha_x),
    .gamma_o  (out_data_o.gamma_x)
  );

  tpt_plane u_plane_y (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .c_i      (in_data_i.r33),
    .s_i      (in_data_i.r34),
    .cp_i     (in_data_i.r43),
    .sp_i     (in_data_i.r44),
    .beta0_i  (cfg.beta_y0),
    .alpha0_i (cfg.alpha_y0),
    .gamma0_i (cfg.gamma_y0),
    .beta_o   (out_data_o.beta_y),
    .alpha_o  (out_data_o.alpha_y),
    .gamma_o  (out_data_o.gamma_y)
  );

  tpt_disp u_disp (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .r11_i    (in_data_i.r11),
    .r12_i    (in_data_i.r12),
    .r21_i    (in_data_i.r21),
    .r22_i    (in_data_i.r22),
    .d14_i    (in_data_i.disp_term_x),
    .d24_i    (in_data_i.disp_slope_term_x),
    .disp0_i  (cfg.disp_x0),
    .slope0_i (cfg.disp_slope_x0),
    .disp_o   (out_data_o.disp_x),
    .slope_o  (out_data_o.disp_slope_x)
  );

  assign out_data_o.last_out = last_q[PIPE_DEPTH-1];

endmodule
